// ===== rtl/core/pps_compare_phase_aligner_assert.svh =====
// Assertion macros for the phase aligner checker
`ifndef PPS_COMPARE_PHASE_ALIGNER_ASSERT_SVH
`define PPS_COMPARE_PHASE_ALIGNER_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define PCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle
`define PCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/pca_pkg.sv =====
`timescale 1ns / 1ps
package pca_pkg;

    typedef enum logic [2:0] {
        OP_SET_FREQ    = 3'd0,
        OP_COMPARE     = 3'd1,
        OP_OFFSET      = 3'd2,
        OP_GNSS_RESYNC = 3'd3,
        OP_NTP_RESYNC  = 3'd4,
        OP_RELOAD      = 3'd5,
        OP_CLEAR_SYNC  = 3'd6,
        OP_UNUSED      = 3'd7
    } t_opcode;

    // configuration register indexes
    localparam logic [2:0] REG_CYC_LO   = 3'd0;
    localparam logic [2:0] REG_CYC_HI   = 3'd1;
    localparam logic [2:0] REG_CYC_FB   = 3'd2;
    localparam logic [2:0] REG_OFF_LO   = 3'd3;
    localparam logic [2:0] REG_OFF_HI   = 3'd4;
    localparam logic [2:0] REG_LEAD     = 3'd5;

    localparam int MAX_WRAPS_DEF = 64;
    localparam logic [15:0] WRAP_SAT   = 16'hFFFF;
    localparam logic [31:0] HIGH_STEP  = 32'h0001_0000;
    localparam logic [31:0] MS_DIV     = 32'd1000;
    // ceil(2^38 / 1000): x / 1000 == (x * MS_RECIP) >> 38 for every 32-bit x
    localparam logic [28:0] MS_RECIP   = 29'd274877907;

    // datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,      // register the input item
        CMD_EXEC,       // simple ops run by this one command
        CMD_DIV_START,  // cycles/1000 by reciprocal multiply
        CMD_NTP_MUL,    // multiply ms by quotient
        CMD_NTP_PROG,
        CMD_OFF_INIT,
        CMD_WRAP_ADD,
        CMD_WRAP_SUB,
        CMD_OFF_DONE
    } t_cmd;

    typedef struct packed {
        t_opcode op;
        logic    need_add;
        logic    need_sub;
    } t_status;

endpackage

// ===== rtl/core/pca_datapath.sv =====
`timescale 1ns / 1ps
module pca_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pca_pkg::t_cmd     i_cmd,
    output pca_pkg::t_status  o_status,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic [2:0]        i_opcode,
    input  logic [31:0]       i_value,
    input  logic [15:0]       i_capture_low,
    input  logic [15:0]       i_capture_high,
    input  logic signed [15:0] i_ntp_offset_ms,
    output logic [15:0]       o_compare_start,
    output logic [15:0]       o_compare_end,
    output logic [15:0]       o_compare_high,
    output logic              o_synced,
    output logic              o_gnss_adjust_pending,
    output logic              o_ntp_adjust_pending,
    output logic              o_fudge_active,
    output logic signed [31:0] o_phase_offset,
    output logic [15:0]       o_wraps_up,
    output logic [15:0]       o_wraps_down,
    output logic [31:0]       o_resync_count,
    output logic [31:0]       o_event_count
);
    import pca_pkg::*;

    // configuration
    logic [31:0] r_cyc_lo, r_cyc_hi, r_cyc_fb, r_off_lo, r_off_hi;
    logic [15:0] r_lead;
    // item latch
    t_opcode     r_op;
    logic [31:0] r_value;
    logic [31:0] r_cap;
    logic [15:0] r_ms;
    // state
    logic [31:0] r_meas, r_capt, r_offs;
    logic [15:0] r_cmp_s, r_cmp_e, r_cmp_h;
    logic        r_sync, r_gnss, r_ntp, r_fudge;
    logic [15:0] r_wup, r_wdn;
    logic [31:0] r_rsc, r_evc;
    // work registers
    logic [31:0] r_acc;     // offset under wrap / ntp adjust
    logic [31:0] r_quo;     // cycles / 1000

    // divide by 1000 as multiply by reciprocal, keep bits 60:38
    logic [60:0] w_recip_prod;
    assign w_recip_prod = {29'd0, r_meas} * {32'd0, MS_RECIP};

    // period programming shared by the compare, resync and reload ops
    logic [31:0] w_prog_in;
    logic        w_prog;
    logic        w_prog_fb;  // use fallback-checked frequency
    logic [31:0] w_meas_chk;
    assign w_meas_chk = (r_meas > r_cyc_hi || r_meas < r_cyc_lo) ? r_cyc_fb : r_meas;

    logic [31:0] w_c;
    logic [15:0] w_hi, w_lo;
    logic        w_hi_zero;
    assign w_c       = w_prog_in - 32'd1;
    assign w_lo      = w_c[15:0];
    assign w_hi_zero = (w_c[31:16] == 16'd0);
    assign w_hi      = w_hi_zero ? 16'd1 : w_c[31:16];

    // compare event with nothing pending: fudge is corrected and cleared
    logic        w_fudge_clr;
    assign w_fudge_clr = (i_cmd == CMD_EXEC) && (r_op == OP_COMPARE) &&
                         !r_gnss && !r_ntp && r_fudge;

    always_comb begin
        w_prog    = 1'b0;
        w_prog_fb = 1'b0;
        w_prog_in = r_meas;
        if (i_cmd == CMD_EXEC) begin
            unique case (r_op)
                OP_COMPARE: begin
                    if (r_gnss) begin
                        w_prog = 1'b1;
                        w_prog_fb = 1'b1;
                        w_prog_in = r_fudge ? w_meas_chk - HIGH_STEP : w_meas_chk;
                    end else if (r_ntp) begin
                        w_prog = 1'b1;
                        w_prog_in = r_fudge ? r_meas + r_offs : r_meas;
                    end else if (r_fudge) begin
                        w_prog = 1'b1;
                        w_prog_fb = 1'b1;
                        w_prog_in = w_meas_chk;
                    end
                end
                OP_GNSS_RESYNC: begin
                    w_prog = 1'b1;
                    w_prog_in = r_meas + r_offs;
                end
                OP_RELOAD: w_prog = 1'b1;
                default: ;
            endcase
        end else if (i_cmd == CMD_NTP_PROG) begin
            w_prog = 1'b1;
            w_prog_in = r_meas + r_acc;
        end
    end

    assign o_status.op       = r_op;
    assign o_status.need_add = $signed(r_acc) < $signed(r_off_lo);
    assign o_status.need_sub = $signed(r_acc) > $signed(r_off_hi);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyc_lo <= 32'd39990000;
            r_cyc_hi <= 32'd40010000;
            r_cyc_fb <= 32'd40000000;
            r_off_lo <= -32'sd20000000;
            r_off_hi <= 32'd20000000;
            r_lead   <= 16'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CYC_LO: r_cyc_lo <= i_cfg_data;
                REG_CYC_HI: r_cyc_hi <= i_cfg_data;
                REG_CYC_FB: r_cyc_fb <= i_cfg_data;
                REG_OFF_LO: r_off_lo <= i_cfg_data;
                REG_OFF_HI: r_off_hi <= i_cfg_data;
                REG_LEAD:   r_lead   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // item latch and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LATCH) begin
            r_op    <= t_opcode'(i_opcode);
            r_value <= i_value;
            r_cap   <= {i_capture_high, i_capture_low};
            r_ms    <= i_ntp_offset_ms;
        end
        unique case (i_cmd)
            CMD_DIV_START: r_quo <= {9'd0, w_recip_prod[60:38]};
            CMD_NTP_MUL:  r_acc <= {{16{r_ms[15]}}, r_ms} * r_quo;
            CMD_OFF_INIT: r_acc <= r_value - r_capt;
            CMD_WRAP_ADD: r_acc <= r_acc + r_meas;
            CMD_WRAP_SUB: r_acc <= r_acc - r_meas;
            default: ;
        endcase
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas  <= 32'd40000000;
            r_capt  <= '0;
            r_offs  <= '0;
            r_cmp_s <= '0;
            r_cmp_e <= '0;
            r_cmp_h <= '0;
            r_sync  <= 1'b0;
            r_gnss  <= 1'b0;
            r_ntp   <= 1'b0;
            r_fudge <= 1'b0;
            r_wup   <= '0;
            r_wdn   <= '0;
            r_rsc   <= '0;
            r_evc   <= '0;
        end else begin
            if (w_prog) begin
                r_cmp_s <= w_lo - r_lead;
                r_cmp_e <= w_lo;
                r_cmp_h <= w_hi;
            end
            // programming can only raise fudge; the plain compare event clears it
            if (w_fudge_clr) r_fudge <= 1'b0;
            else if (w_prog && w_hi_zero) r_fudge <= 1'b1;
            if (w_prog_fb) r_meas <= w_meas_chk;
            if (i_cmd == CMD_EXEC) begin
                unique case (r_op)
                    OP_SET_FREQ: r_meas <= r_value;
                    OP_COMPARE: begin
                        if (r_gnss) begin
                            if (!r_fudge) r_sync <= 1'b1;
                            r_gnss <= 1'b0;
                        end else if (r_ntp) begin
                            if (!r_fudge) r_sync <= 1'b1;
                            r_ntp <= 1'b0;
                        end else if (r_fudge) begin
                            r_sync  <= 1'b1;
                        end
                        r_evc  <= r_evc + 32'd1;
                        r_capt <= r_cap;
                    end
                    OP_GNSS_RESYNC: begin
                        r_gnss <= 1'b1;
                        r_wup  <= '0;
                        r_wdn  <= '0;
                        r_rsc  <= r_rsc + 32'd1;
                    end
                    OP_CLEAR_SYNC: r_sync <= 1'b0;
                    default: ;
                endcase
            end
            if (i_cmd == CMD_NTP_PROG) begin
                r_ntp <= 1'b1;
                r_rsc <= r_rsc + 32'd1;
            end
            if (i_cmd == CMD_WRAP_ADD && r_wdn != WRAP_SAT) r_wdn <= r_wdn + 16'd1;
            if (i_cmd == CMD_WRAP_SUB && r_wup != WRAP_SAT) r_wup <= r_wup + 16'd1;
            if (i_cmd == CMD_OFF_DONE) r_offs <= r_acc;
        end
    end

    assign o_compare_start       = r_cmp_s;
    assign o_compare_end         = r_cmp_e;
    assign o_compare_high        = r_cmp_h;
    assign o_synced              = r_sync;
    assign o_gnss_adjust_pending = r_gnss;
    assign o_ntp_adjust_pending  = r_ntp;
    assign o_fudge_active        = r_fudge;
    assign o_phase_offset        = r_offs;
    assign o_wraps_up            = r_wup;
    assign o_wraps_down          = r_wdn;
    assign o_resync_count        = r_rsc;
    assign o_event_count         = r_evc;
endmodule

// ===== rtl/core/pca_ctrl.sv =====
`timescale 1ns / 1ps
module pca_ctrl #(
    parameter int MAX_WRAPS = pca_pkg::MAX_WRAPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  pca_pkg::t_status i_status,
    output pca_pkg::t_cmd    o_cmd
);
    import pca_pkg::*;

    localparam int CW = $clog2(MAX_WRAPS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DIV, S_PROG,
        S_ADD, S_SUB, S_DONE, S_OUT
    } t_state;

    t_state      r_state;
    logic [CW-1:0] r_cnt;
    logic        r_valid;

    // no transfer is taken while in reset
    assign o_stall = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid = r_valid;

    // command decode
    always_comb begin
        o_cmd = CMD_NONE;
        unique case (r_state)
            S_IDLE:     if (i_valid) o_cmd = CMD_LATCH;
            S_DISPATCH: begin
                if (i_status.op == OP_NTP_RESYNC) o_cmd = CMD_DIV_START;
                else if (i_status.op == OP_OFFSET) o_cmd = CMD_OFF_INIT;
                else o_cmd = CMD_EXEC;
            end
            S_DIV:  o_cmd = CMD_NTP_MUL;
            S_PROG: o_cmd = CMD_NTP_PROG;
            S_ADD:  if (i_status.need_add && r_cnt != CW'(MAX_WRAPS)) o_cmd = CMD_WRAP_ADD;
            S_SUB:  if (i_status.need_sub && r_cnt != CW'(MAX_WRAPS)) o_cmd = CMD_WRAP_SUB;
            S_DONE: o_cmd = CMD_OFF_DONE;
            default: ;
        endcase
    end

    // sequencer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    r_cnt <= '0;
                    if (i_status.op == OP_NTP_RESYNC) r_state <= S_DIV;
                    else if (i_status.op == OP_OFFSET) r_state <= S_ADD;
                    else begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end
                end
                S_DIV: r_state <= S_PROG;
                S_PROG: begin
                    r_state <= S_OUT;
                    r_valid <= 1'b1;
                end
                S_ADD: begin
                    if (o_cmd == CMD_WRAP_ADD) r_cnt <= r_cnt + CW'(1);
                    else begin
                        r_cnt   <= '0;
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (o_cmd == CMD_WRAP_SUB) r_cnt <= r_cnt + CW'(1);
                    else r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_OUT;
                    r_valid <= 1'b1;
                end
                S_OUT: if (!i_stall) begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/pps_compare_phase_aligner.sv =====
`timescale 1ns / 1ps
// PPS compare-output phase aligner. One item is taken at a time; its result is
// held on the outputs until transferred, and the next item can be taken the cycle
// after that. Most opcodes are executed directly; an NTP resync divides by 1000
// as a reciprocal multiply, then does the ms multiply, then the period update;
// an offset computation forms the offset, then takes up to MAX_WRAPS add wrap
// steps and up to MAX_WRAPS subtract wrap steps, one wrap step per cycle, then
// stores the offset.
module pps_compare_phase_aligner #(
    parameter int MAX_WRAPS = pca_pkg::MAX_WRAPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_opcode,
    input  logic [31:0]       i_value,
    input  logic [15:0]       i_capture_low,
    input  logic [15:0]       i_capture_high,
    input  logic signed [15:0] i_ntp_offset_ms,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [15:0]       o_compare_start,
    output logic [15:0]       o_compare_end,
    output logic [15:0]       o_compare_high,
    output logic              o_synced,
    output logic              o_gnss_adjust_pending,
    output logic              o_ntp_adjust_pending,
    output logic              o_fudge_active,
    output logic signed [31:0] o_phase_offset,
    output logic [15:0]       o_wraps_up,
    output logic [15:0]       o_wraps_down,
    output logic [31:0]       o_resync_count,
    output logic [31:0]       o_event_count
);
    import pca_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    pca_ctrl #(.MAX_WRAPS(MAX_WRAPS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    pca_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_opcode(i_opcode), .i_value(i_value),
        .i_capture_low(i_capture_low), .i_capture_high(i_capture_high),
        .i_ntp_offset_ms(i_ntp_offset_ms),
        .o_compare_start(o_compare_start), .o_compare_end(o_compare_end),
        .o_compare_high(o_compare_high), .o_synced(o_synced),
        .o_gnss_adjust_pending(o_gnss_adjust_pending),
        .o_ntp_adjust_pending(o_ntp_adjust_pending),
        .o_fudge_active(o_fudge_active), .o_phase_offset(o_phase_offset),
        .o_wraps_up(o_wraps_up), .o_wraps_down(o_wraps_down),
        .o_resync_count(o_resync_count), .o_event_count(o_event_count)
    );
endmodule

// ===== rtl/core/pca_checker.sv =====
`timescale 1ns / 1ps
`include "pps_compare_phase_aligner_assert.svh"
module pca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall
);
    // a transferred result is gone the next cycle
    `PCA_ASSERT_NEXT(a_drop, i_clk, i_rst_n, o_valid && !i_stall, !o_valid)
    // no item taken while a result is pending
    `PCA_ASSERT_IMP(a_one_item, i_clk, i_rst_n, o_valid, o_stall)
    // result stays while stalled
    `PCA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    // an accepted item blocks the next cycle's input
    `PCA_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule

bind pps_compare_phase_aligner pca_checker u_pca_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import pca_pkg::*;

    localparam int WRAP_LIMIT = MAX_WRAPS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] start_word;
        logic [15:0] end_word;
        logic [15:0] high_word;
        logic        synced;
        logic        gnss_pend;
        logic        ntp_pend;
        logic        fudge;
        logic [31:0] offset;
        logic [15:0] wraps_up;
        logic [15:0] wraps_down;
        logic [31:0] resyncs;
        logic [31:0] events;
    } t_status_word;

    // Aligner behavior model and the queue of pending expected status words
    class aligner_scoreboard;
        logic [31:0] lower_lim, upper_lim, fallback, off_lo, off_hi;
        logic [15:0] lead;
        logic [31:0] cycles, captured, offset;
        logic [15:0] cmp_start, cmp_end, cmp_high;
        logic        synced, gnss_pend, ntp_pend, fudge;
        logic [15:0] wr_up, wr_down;
        logic [31:0] resyncs, events;
        t_status_word pending_q[$];
        int errors;

        function new();
            lower_lim = 32'd39990000;
            upper_lim = 32'd40010000;
            fallback = 32'd40000000;
            off_lo = -32'sd20000000;
            off_hi = 32'd20000000;
            lead = 16'd50;
            cycles = 32'd40000000;
            captured = '0;
            offset = '0;
            cmp_start = '0;
            cmp_end = '0;
            cmp_high = '0;
            synced = 0;
            gnss_pend = 0;
            ntp_pend = 0;
            fudge = 0;
            wr_up = '0;
            wr_down = '0;
            resyncs = '0;
            events = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_CYC_LO: lower_lim = data;
                REG_CYC_HI: upper_lim = data;
                REG_CYC_FB: fallback = data;
                REG_OFF_LO: off_lo = data;
                REG_OFF_HI: off_hi = data;
                REG_LEAD:   lead = data[15:0];
                default: ;
            endcase
        endfunction

        function void set_period(logic [31:0] period);
            logic [31:0] c;
            logic [15:0] hi;
            c = period - 32'd1;
            hi = c[31:16];
            if (hi == 16'd0) begin
                hi = 16'd1;
                fudge = 1;
            end
            cmp_start = c[15:0] - lead;
            cmp_end = c[15:0];
            cmp_high = hi;
        endfunction

        function void check_cycles();
            if (cycles > upper_lim || cycles < lower_lim) cycles = fallback;
        endfunction

        // Note an accepted input transfer and queue its expected status
        function void note_input(t_opcode op, logic [31:0] value, logic [15:0] cap_lo,
                                 logic [15:0] cap_hi, logic signed [15:0] ms);
            logic [31:0] off, adj;
            t_status_word s;
            case (op)
                OP_SET_FREQ: cycles = value;
                OP_COMPARE: begin
                    if (gnss_pend) begin
                        check_cycles();
                        if (fudge) set_period(cycles - HIGH_STEP);
                        else begin
                            set_period(cycles);
                            synced = 1;
                        end
                        gnss_pend = 0;
                    end else if (ntp_pend) begin
                        if (fudge) set_period(cycles + offset);
                        else begin
                            set_period(cycles);
                            synced = 1;
                        end
                        ntp_pend = 0;
                    end else if (fudge) begin
                        check_cycles();
                        set_period(cycles);
                        fudge = 0;
                        synced = 1;
                    end
                    events++;
                    captured = {cap_hi, cap_lo};
                end
                OP_OFFSET: begin
                    off = value - captured;
                    for (int n = 0; n < WRAP_LIMIT && $signed(off) < $signed(off_lo); n++) begin
                        off += cycles;
                        if (wr_down != WRAP_SAT) wr_down++;
                    end
                    for (int n = 0; n < WRAP_LIMIT && $signed(off) > $signed(off_hi); n++) begin
                        off -= cycles;
                        if (wr_up != WRAP_SAT) wr_up++;
                    end
                    offset = off;
                end
                OP_GNSS_RESYNC: begin
                    set_period(cycles + offset);
                    gnss_pend = 1;
                    wr_up = '0;
                    wr_down = '0;
                    resyncs++;
                end
                OP_NTP_RESYNC: begin
                    adj = {{16{ms[15]}}, ms} * (cycles / MS_DIV);
                    set_period(cycles + adj);
                    ntp_pend = 1;
                    resyncs++;
                end
                OP_RELOAD: set_period(cycles);
                OP_CLEAR_SYNC: synced = 0;
                default: ;
            endcase
            s = '{cmp_start, cmp_end, cmp_high, synced, gnss_pend, ntp_pend, fudge,
                  offset, wr_up, wr_down, resyncs, events};
            pending_q.push_back(s);
        endfunction

        // Compare one output transfer with the oldest expectation
        function void check_result(t_status_word got);
            t_status_word exp_s;
            if (pending_q.size() == 0) begin
                $error("output transfer with no expectation pending");
                errors++;
                return;
            end
            exp_s = pending_q.pop_front();
            if (got.start_word != exp_s.start_word) begin
                $error("compare_start exp %h got %h", exp_s.start_word, got.start_word);
                errors++;
            end
            if (got.end_word != exp_s.end_word) begin
                $error("compare_end exp %h got %h", exp_s.end_word, got.end_word);
                errors++;
            end
            if (got.high_word != exp_s.high_word) begin
                $error("compare_high exp %h got %h", exp_s.high_word, got.high_word);
                errors++;
            end
            if (got.synced !== exp_s.synced) begin
                $error("synced exp %b got %b", exp_s.synced, got.synced);
                errors++;
            end
            if (got.gnss_pend !== exp_s.gnss_pend) begin
                $error("gnss_adjust_pending exp %b got %b", exp_s.gnss_pend, got.gnss_pend);
                errors++;
            end
            if (got.ntp_pend !== exp_s.ntp_pend) begin
                $error("ntp_adjust_pending exp %b got %b", exp_s.ntp_pend, got.ntp_pend);
                errors++;
            end
            if (got.fudge !== exp_s.fudge) begin
                $error("fudge_active exp %b got %b", exp_s.fudge, got.fudge);
                errors++;
            end
            if (got.offset !== exp_s.offset) begin
                $error("phase_offset exp %h got %h", exp_s.offset, got.offset);
                errors++;
            end
            if (got.wraps_up !== exp_s.wraps_up) begin
                $error("wraps_up exp %h got %h", exp_s.wraps_up, got.wraps_up);
                errors++;
            end
            if (got.wraps_down !== exp_s.wraps_down) begin
                $error("wraps_down exp %h got %h", exp_s.wraps_down, got.wraps_down);
                errors++;
            end
            if (got.resyncs !== exp_s.resyncs) begin
                $error("resync_count exp %h got %h", exp_s.resyncs, got.resyncs);
                errors++;
            end
            if (got.events !== exp_s.events) begin
                $error("event_count exp %h got %h", exp_s.events, got.events);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_opcode = '0;
    logic [31:0] i_value = '0;
    logic [15:0] i_capture_low = '0;
    logic [15:0] i_capture_high = '0;
    logic signed [15:0] i_ntp_offset_ms = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [15:0] o_compare_start, o_compare_end, o_compare_high;
    logic        o_synced, o_gnss_adjust_pending, o_ntp_adjust_pending, o_fudge_active;
    logic signed [31:0] o_phase_offset;
    logic [15:0] o_wraps_up, o_wraps_down;
    logic [31:0] o_resync_count, o_event_count;

    aligner_scoreboard sb;
    bit out_idle_on = 1;
    int idle_cycles = 0;
    int out_wait = 0;

    pps_compare_phase_aligner u_top (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // Output side: stall drawn per result, check every transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result('{o_compare_start, o_compare_end, o_compare_high, o_synced,
                              o_gnss_adjust_pending, o_ntp_adjust_pending, o_fudge_active,
                              o_phase_offset, o_wraps_up, o_wraps_down,
                              o_resync_count, o_event_count});
            out_wait = out_idle_on ? $urandom_range(0, 16) : 0;
            i_stall <= (out_wait != 0);
        end else if (i_rst_n && o_valid && out_wait > 0) begin
            out_wait = out_wait - 1;
            i_stall <= (out_wait != 0);
        end
    end

    // Watchdog on cycles without any transfer or config write
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, data);
    endtask

    // Drive one item with an optional random lead-in gap
    task automatic send_item(t_opcode op, logic [31:0] value, logic [15:0] cap_lo,
                             logic [15:0] cap_hi, logic signed [15:0] ms, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_opcode <= op;
        i_value <= value;
        i_capture_low <= cap_lo;
        i_capture_high <= cap_hi;
        i_ntp_offset_ms <= ms;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(op, value, cap_lo, cap_hi, ms);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Random item biased toward plausible resync and compare sequences
    task automatic random_item(bit gaps);
        int pick;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        v = $urandom;
        if (pick < 10)
            send_item(OP_SET_FREQ, $urandom_range(0, 3) == 0 ? v :
                      32'd39980000 + $urandom_range(0, 40000), 0, 0, 0, gaps);
        else if (pick < 12)
            send_item(OP_SET_FREQ, $urandom_range(0, 1) ? $urandom_range(1, 200000) : 0,
                      0, 0, 0, gaps);
        else if (pick < 40)
            send_item(OP_COMPARE, 0, 16'($urandom), 16'($urandom), 0, gaps);
        else if (pick < 60)
            send_item(OP_OFFSET, $urandom_range(0, 1) ? v :
                      sb.captured + $urandom_range(0, 200000000), 0, 0, 0, gaps);
        else if (pick < 72)
            send_item(OP_GNSS_RESYNC, 0, 0, 0, 0, gaps);
        else if (pick < 82)
            send_item(OP_NTP_RESYNC, 0, 0, 0, 16'($urandom), gaps);
        else if (pick < 90)
            send_item(OP_RELOAD, 0, 0, 0, 0, gaps);
        else if (pick < 97)
            send_item(OP_CLEAR_SYNC, 0, 0, 0, 0, gaps);
        else
            send_item(OP_UNUSED, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                      gaps);
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: every opcode, field extremes, fudge and wrap limits
        send_item(OP_RELOAD, 0, 0, 0, 0, 0);
        send_item(OP_GNSS_RESYNC, 0, 0, 0, 0, 0);
        send_item(OP_COMPARE, 0, 16'hFFFF, 16'hFFFF, 0, 0);
        send_item(OP_OFFSET, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_item(OP_OFFSET, 32'h7FFF_FFFF, 0, 0, 0, 0);
        send_item(OP_NTP_RESYNC, 0, 0, 0, 16'sh7FFF, 0);
        send_item(OP_COMPARE, 0, 0, 0, 0, 0);
        send_item(OP_NTP_RESYNC, 0, 0, 0, -16'sh8000, 0);
        send_item(OP_SET_FREQ, 32'd1000, 0, 0, 0, 0);
        send_item(OP_RELOAD, 0, 0, 0, 0, 0);
        send_item(OP_NTP_RESYNC, 0, 0, 0, 16'sd5, 0);
        send_item(OP_COMPARE, 0, 16'h1234, 16'h0, 0, 0);
        send_item(OP_COMPARE, 0, 16'h0, 16'h0, 0, 0);
        send_item(OP_SET_FREQ, 32'd0, 0, 0, 0, 0);
        send_item(OP_OFFSET, 32'h8000_0000, 0, 0, 0, 0);
        send_item(OP_GNSS_RESYNC, 0, 0, 0, 0, 0);
        send_item(OP_COMPARE, 0, 0, 0, 0, 0);
        send_item(OP_SET_FREQ, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_item(OP_RELOAD, 0, 0, 0, 0, 0);
        send_item(OP_CLEAR_SYNC, 0, 0, 0, 0, 0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, -16'sd1, 0);
        drain();

        // Random phases across register settings, extremes included
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: ;
                1: begin
                    cfg_write(REG_CYC_LO, 32'd0);
                    cfg_write(REG_CYC_HI, 32'hFFFF_FFFF);
                    cfg_write(REG_CYC_FB, 32'd1);
                    cfg_write(REG_OFF_LO, 32'h8000_0000);
                    cfg_write(REG_OFF_HI, 32'h7FFF_FFFF);
                    cfg_write(REG_LEAD, 32'd65535);
                end
                2: begin
                    cfg_write(REG_CYC_LO, 32'hFFFF_FFFF);
                    cfg_write(REG_CYC_HI, 32'd0);
                    cfg_write(REG_CYC_FB, 32'hFFFF_FFFF);
                    cfg_write(REG_OFF_LO, 32'd0);
                    cfg_write(REG_OFF_HI, 32'd0);
                    cfg_write(REG_LEAD, 32'd0);
                end
                3: begin
                    cfg_write(REG_CYC_LO, 32'd50000);
                    cfg_write(REG_CYC_HI, 32'd70000);
                    cfg_write(REG_CYC_FB, 32'd65536);
                    cfg_write(REG_OFF_LO, -32'sd1000);
                    cfg_write(REG_OFF_HI, 32'd1000);
                    cfg_write(REG_LEAD, $urandom_range(0, 65535));
                end
                default: begin
                    cfg_write(REG_CYC_LO, 32'd39990000);
                    cfg_write(REG_CYC_HI, 32'd40010000);
                    cfg_write(REG_CYC_FB, 32'd40000000);
                    cfg_write(REG_OFF_LO, -32'sd20000000);
                    cfg_write(REG_OFF_HI, 32'd20000000);
                    cfg_write(REG_LEAD, 32'd50);
                end
            endcase
            out_idle_on = (phase != 2);
            for (int k = 0; k < 250; k++)
                random_item(phase != 2);
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pca_pkg.sv
rtl/core/pca_datapath.sv
rtl/core/pca_ctrl.sv
rtl/core/pps_compare_phase_aligner.sv
rtl/core/pca_checker.sv
test/tb_top.sv
